// ----- sv/rhc_pkg.sv -----
// rhc_pkg: widths, constants and pipeline word types of the rgb to hsv converter
// used by every module of the converter; depends on nothing else
package rhc_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int CW           = CHANNEL_BITS;
  localparam int FULL_SCALE   = (1 << CW) - 1;

  localparam int HUE_W  = 9;
  localparam int PCT_W  = 7;
  localparam int QUOT_W = 7;                    // every quotient here is below 128
  localparam int DIV_W  = CW + QUOT_W;          // dividends stay below 128 * divisor
  localparam int DVS_W  = CW + QUOT_W - 1;      // divisor pre-shifted for the top bit

  localparam int DIV_STEPS = QUOT_W;            // one quotient bit per stage
  localparam int NST       = DIV_STEPS + 3;     // minmax, scale, div steps, finish

  localparam int IN_W         = ((3 * CW + 7) / 8) * 8;
  localparam int OUT_FIELD_W  = HUE_W + 2 * PCT_W;
  localparam int OUT_W        = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int HUE_SCALE    = 60;
  localparam int PCT_SCALE    = 100;
  localparam int HUE_WRAP     = 360;
  localparam int HUE_BASE_RED = 300;            // 360 - 60, offset folded into the dividend
  localparam int HUE_BASE_GRN = 60;             // 120 - 60
  localparam int HUE_BASE_BLU = 180;            // 240 - 60

  // value = max * 100 / full scale as a reciprocal multiply, rounded-up constant
  // with enough fraction bits that the floor is exact over the whole channel range
  localparam int     VAL_SHIFT  = 2 * CW + 1;
  localparam int     VAL_MUL_W  = CW + 8;
  localparam int     VAL_PROD_W = CW + VAL_MUL_W;
  localparam longint VAL_MUL    =
    ((longint'(PCT_SCALE) << VAL_SHIFT) + FULL_SCALE - 1) / FULL_SCALE;

  typedef enum logic [1:0] {
    BR_RED,
    BR_GREEN,
    BR_BLUE
  } branch_e;

  typedef struct packed {
    logic [CW-1:0] mx;
    logic [CW-1:0] diff;
    logic [CW:0]   span;      // other difference plus diff, 0 .. 2*diff
    branch_e       branch;
  } prep_t;

  typedef struct packed {
    logic [DIV_W-1:0]  rem;
    logic [DVS_W-1:0]  dvs;
    logic [QUOT_W-1:0] quot;
  } div_lane_t;

  typedef struct packed {
    div_lane_t        hue;
    div_lane_t        sat;
    logic [PCT_W-1:0] val_pct;
    branch_e          branch;
    logic             hue_zero;
    logic             sat_zero;
  } div_word_t;

endpackage

// ----- sv/rhc_minmax.sv -----
// rhc_minmax: first pipeline stage, channel max / min, difference and hue branch
// depends on rhc_pkg
module rhc_minmax (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [rhc_pkg::CW-1:0]   red_i,
  input  logic [rhc_pkg::CW-1:0]   green_i,
  input  logic [rhc_pkg::CW-1:0]   blue_i,
  output rhc_pkg::prep_t           prep_o
);
  import rhc_pkg::*;

  logic [CW-1:0] mx, mn, hi, lo;
  logic [CW+1:0] span_full;
  prep_t         prep_d, prep_q;

  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx)  mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn)  mn = blue_i;

    // red wins ties over green, green over blue
    if (red_i == mx) begin
      prep_d.branch = BR_RED;
      hi = green_i;
      lo = blue_i;
    end else if (green_i == mx) begin
      prep_d.branch = BR_GREEN;
      hi = blue_i;
      lo = red_i;
    end else begin
      prep_d.branch = BR_BLUE;
      hi = red_i;
      lo = green_i;
    end

    // hi - lo + max - min never goes negative
    span_full = {2'b00, hi} + {2'b00, mx} - {2'b00, lo} - {2'b00, mn};

    prep_d.mx   = mx;
    prep_d.diff = mx - mn;
    prep_d.span = span_full[CW:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) prep_q <= prep_d;
  end

  assign prep_o = prep_q;

endmodule

// ----- sv/rhc_scale.sv -----
// rhc_scale: second pipeline stage, dividends and divisors of the two dividers and the value
// depends on rhc_pkg
module rhc_scale (
  input  logic               clk_i,
  input  logic               en_i,
  input  rhc_pkg::prep_t     prep_i,
  output rhc_pkg::div_word_t word_o
);
  import rhc_pkg::*;

  div_word_t               word_d, word_q;
  logic [VAL_PROD_W-1:0]   val_prod;

  always_comb begin
    word_d.hue.rem  = DIV_W'(prep_i.span) * DIV_W'(HUE_SCALE);
    word_d.hue.dvs  = DVS_W'(prep_i.diff) << (QUOT_W - 1);
    word_d.hue.quot = '0;

    word_d.sat.rem  = DIV_W'(prep_i.diff) * DIV_W'(PCT_SCALE);
    word_d.sat.dvs  = DVS_W'(prep_i.mx) << (QUOT_W - 1);
    word_d.sat.quot = '0;

    // divide by full scale through the reciprocal constant
    val_prod        = VAL_PROD_W'(prep_i.mx) * VAL_PROD_W'(VAL_MUL);
    word_d.val_pct  = val_prod[VAL_SHIFT +: PCT_W];

    word_d.branch   = prep_i.branch;
    word_d.hue_zero = (prep_i.diff == '0);
    word_d.sat_zero = (prep_i.mx == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ----- sv/rhc_div_step.sv -----
// rhc_div_step: one restoring division step for the hue and saturation lanes
// depends on rhc_pkg
module rhc_div_step (
  input  logic               clk_i,
  input  logic               en_i,
  input  rhc_pkg::div_word_t word_i,
  output rhc_pkg::div_word_t word_o
);
  import rhc_pkg::*;

  div_word_t word_d, word_q;

  function automatic div_lane_t lane_step(div_lane_t l);
    div_lane_t        r;
    logic [DIV_W-1:0] dvs_ext;
    dvs_ext = DIV_W'(l.dvs);
    r       = l;
    if (l.rem >= dvs_ext) begin
      r.rem  = l.rem - dvs_ext;
      r.quot = {l.quot[QUOT_W-2:0], 1'b1};
    end else begin
      r.quot = {l.quot[QUOT_W-2:0], 1'b0};
    end
    // divisor walks one bit down for the next quotient bit
    r.dvs = l.dvs >> 1;
    return r;
  endfunction

  always_comb begin
    word_d     = word_i;
    word_d.hue = lane_step(word_i.hue);
    word_d.sat = lane_step(word_i.sat);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ----- sv/rhc_finish.sv -----
// rhc_finish: last pipeline stage, hue offset and wrap, zero cases, output register
// depends on rhc_pkg
module rhc_finish (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  rhc_pkg::div_word_t      word_i,
  output logic [rhc_pkg::OUT_W-1:0] tdata_o
);
  import rhc_pkg::*;

  logic [HUE_W-1:0] base, hue_sum, hue;
  logic [PCT_W-1:0] sat, val;
  logic [OUT_W-1:0] tdata_d, tdata_q;

  always_comb begin
    case (word_i.branch)
      BR_RED:   base = HUE_W'(HUE_BASE_RED);
      BR_GREEN: base = HUE_W'(HUE_BASE_GRN);
      BR_BLUE:  base = HUE_W'(HUE_BASE_BLU);
      default:  base = '0;
    endcase
    hue_sum = base + HUE_W'(word_i.hue.quot);
    if (word_i.hue_zero) begin
      hue = '0;
    end else if (hue_sum >= HUE_W'(HUE_WRAP)) begin
      hue = hue_sum - HUE_W'(HUE_WRAP);
    end else begin
      hue = hue_sum;
    end
    sat = word_i.sat_zero ? '0 : PCT_W'(word_i.sat.quot);
    val = word_i.val_pct;
    tdata_d = OUT_W'({val, sat, hue});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) tdata_q <= tdata_d;
  end

  assign tdata_o = tdata_q;

endmodule

// ----- sv/rgb_to_hsv_convert_top.sv -----
// rgb_to_hsv_convert_top: pipelined rgb to hsv pixel converter, top level
// depends on rhc_pkg, rhc_minmax, rhc_scale, rhc_div_step and rhc_finish
//
// usage:
//   slave stream takes one pixel per transfer, tdata = red, green, blue from bit 0
//   master stream gives hue 0..359, saturation 0..100 and value 0..100 per pixel
//   one result per pixel, in order
// path: a pixel accepted on the slave side passes the min/max stage, the dividend and
//   value stage, 7 division stages and the output stage to reach the master side
// throughput: one pixel per clock unless stalled; the hue and saturation dividers each resolve one
//   quotient bit per pipeline stage, so a new pixel enters every cycle while nothing stalls
// stall: every stage has its own valid bit and holds while the next stage is full
//   and not moving; empty stages keep filling, so s_axis_tready_o drops only
//   once all 10 stages hold pixels and m_axis_tready_i is low
// reset: rst_ni clears all valid bits, the pipeline comes up empty and ready
module rgb_to_hsv_convert_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [rhc_pkg::IN_W-1:0]    s_axis_tdata_i,   // red, green, blue
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [rhc_pkg::OUT_W-1:0]   m_axis_tdata_o    // hue_degrees, saturation_pct, value_pct
);
  import rhc_pkg::*;

  logic [NST-1:0] vld_q, vld_d;
  logic [NST-1:0] en;
  prep_t          prep;
  div_word_t      div_w [DIV_STEPS+1];

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en[NST-1] = !vld_q[NST-1] || m_axis_tready_i;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (en[0]) vld_d[0] = s_axis_tvalid_i;
    for (int i = 1; i < NST; i++) begin
      if (en[i]) vld_d[i] = vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = vld_q[NST-1];

  rhc_minmax u_minmax (
    .clk_i   (clk_i),
    .en_i    (en[0]),
    .red_i   (s_axis_tdata_i[CW-1:0]),
    .green_i (s_axis_tdata_i[2*CW-1:CW]),
    .blue_i  (s_axis_tdata_i[3*CW-1:2*CW]),
    .prep_o  (prep)
  );

  rhc_scale u_scale (
    .clk_i  (clk_i),
    .en_i   (en[1]),
    .prep_i (prep),
    .word_o (div_w[0])
  );

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    rhc_div_step u_step (
      .clk_i  (clk_i),
      .en_i   (en[k+2]),
      .word_i (div_w[k]),
      .word_o (div_w[k+1])
    );
  end

  rhc_finish u_finish (
    .clk_i   (clk_i),
    .en_i    (en[NST-1]),
    .word_i  (div_w[DIV_STEPS]),
    .tdata_o (m_axis_tdata_o)
  );

  // back pressure reaches the input only with every stage occupied
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&vld_q))
    else $error("input stalled while a pipeline stage is empty");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[HUE_W-1:0] < HUE_W'(HUE_WRAP)))
    else $error("hue out of range");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tdata_o[HUE_W+PCT_W-1:HUE_W] <= PCT_W'(PCT_SCALE))
                         && (m_axis_tdata_o[HUE_W+2*PCT_W-1:HUE_W+PCT_W]
                             <= PCT_W'(PCT_SCALE))))
    else $error("saturation or value above 100");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// testbench: stream-level check of rgb_to_hsv_convert_top against an integer hsv predictor
// depends on rhc_pkg and rgb_to_hsv_convert_top; runs directed pixels, then random phases
module testbench;
  import rhc_pkg::*;

  localparam int HUE_STEP = 60;
  localparam int HUE_RED  = 360;
  localparam int HUE_GRN  = 120;
  localparam int HUE_BLU  = 240;
  localparam int PCT      = 100;
  localparam int PHASE_PIXELS = 408;
  localparam int MAX_CH   = (1 << CW) - 1;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] val;
  } hsv_t;

  logic              clk_i;
  logic              rst_ni;
  logic              drv_valid = 1'b0;
  logic [IN_W-1:0]   drv_pixel = '0;
  logic              sink_ready = 1'b0;
  logic              s_axis_tready_o;
  logic              m_axis_tvalid_o;
  logic [OUT_W-1:0]  m_axis_tdata_o;

  logic [IN_W-1:0]   pixel_q[$];
  hsv_t              hsv_expect_q[$];
  logic              pix_fire = 1'b0;
  int                send_idle_pct = 0;
  int                sink_stall_pct = 0;
  bit                failed = 1'b0;

  rgb_to_hsv_convert_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (drv_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (drv_pixel),        // red, green, blue
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (sink_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)    // hue_degrees, saturation_pct, value_pct
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic hsv_t hsv_predict(logic [CW-1:0] r, logic [CW-1:0] g, logic [CW-1:0] b);
    int   mx, mn, d, num;
    hsv_t h;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    if (d == 0) begin
      h.hue = '0;
    end else begin
      // red wins ties over green, green over blue
      if (r == mx) num = HUE_STEP * (int'(g) - int'(b)) + HUE_RED * d;
      else if (g == mx) num = HUE_STEP * (int'(b) - int'(r)) + HUE_GRN * d;
      else num = HUE_STEP * (int'(r) - int'(g)) + HUE_BLU * d;
      h.hue = HUE_W'((num / d) % HUE_RED);
    end
    h.sat = (mx == 0) ? '0 : PCT_W'((PCT * d) / mx);
    h.val = PCT_W'((PCT * mx) / FULL_SCALE);
    return h;
  endfunction

  function automatic logic [IN_W-1:0] pack_pixel(int r, int g, int b);
    return IN_W'({CW'(b), CW'(g), CW'(r)});
  endfunction

  // driver: holds an item until its transfer, then takes the next one
  always @(negedge clk_i) begin
    if (!drv_valid || pix_fire) begin
      if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_valid <= 1'b1;
        drv_pixel <= pixel_q.pop_front();
      end else begin
        drv_valid <= 1'b0;
      end
    end
    sink_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // input side monitor: predict on every accepted pixel
  always @(posedge clk_i) begin
    if (rst_ni && drv_valid && s_axis_tready_o) begin
      hsv_expect_q.push_back(hsv_predict(drv_pixel[CW-1:0], drv_pixel[CW +: CW],
                                         drv_pixel[2*CW +: CW]));
      pix_fire <= 1'b1;
    end else begin
      pix_fire <= 1'b0;
    end
  end

  // output side monitor
  always @(posedge clk_i) begin
    hsv_t got, want;
    if (rst_ni && m_axis_tvalid_o && sink_ready) begin
      got.hue = m_axis_tdata_o[HUE_W-1:0];
      got.sat = m_axis_tdata_o[HUE_W +: PCT_W];
      got.val = m_axis_tdata_o[HUE_W + PCT_W +: PCT_W];
      if (hsv_expect_q.size() == 0) begin
        $error("unexpected result transfer: hue %0d sat %0d val %0d",
               got.hue, got.sat, got.val);
        failed = 1'b1;
      end else begin
        want = hsv_expect_q.pop_front();
        if (got.hue !== want.hue) begin
          $error("hue_degrees: expected %0d, got %0d", want.hue, got.hue);
          failed = 1'b1;
        end
        if (got.sat !== want.sat) begin
          $error("saturation_pct: expected %0d, got %0d", want.sat, got.sat);
          failed = 1'b1;
        end
        if (got.val !== want.val) begin
          $error("value_pct: expected %0d, got %0d", want.val, got.val);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic queue_random_pixels(int count);
    int r, g, b, base, kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(9);
      r = $urandom_range(MAX_CH);
      g = $urandom_range(MAX_CH);
      b = $urandom_range(MAX_CH);
      case (kind)
        5: begin
          g = r;
          b = r;
        end
        6: begin
          // at least two channels share the maximum
          case ($urandom_range(2))
            0: begin
              g = r;
              b = $urandom_range(r);
            end
            1: begin
              b = g;
              r = $urandom_range(g);
            end
            default: begin
              b = r;
              g = $urandom_range(r);
            end
          endcase
        end
        7: begin
          base = $urandom_range(MAX_CH - 3);
          r = base + $urandom_range(3);
          g = base + $urandom_range(3);
          b = base + $urandom_range(3);
        end
        8: begin
          r = $urandom_range(1) ? MAX_CH : 0;
          g = $urandom_range(1) ? MAX_CH : 0;
        end
        default: ;
      endcase
      pixel_q.push_back(pack_pixel(r, g, b));
    end
  endtask

  task automatic wait_drained();
    while (pixel_q.size() > 0 || drv_valid || hsv_expect_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // black, white, greys, primaries, secondaries, ties and hue wrap
    pixel_q.push_back(pack_pixel(0, 0, 0));
    pixel_q.push_back(pack_pixel(255, 255, 255));
    pixel_q.push_back(pack_pixel(128, 128, 128));
    pixel_q.push_back(pack_pixel(1, 1, 1));
    pixel_q.push_back(pack_pixel(255, 0, 0));
    pixel_q.push_back(pack_pixel(0, 255, 0));
    pixel_q.push_back(pack_pixel(0, 0, 255));
    pixel_q.push_back(pack_pixel(255, 255, 0));
    pixel_q.push_back(pack_pixel(0, 255, 255));
    pixel_q.push_back(pack_pixel(255, 0, 255));
    pixel_q.push_back(pack_pixel(255, 0, 1));
    pixel_q.push_back(pack_pixel(1, 0, 0));
    pixel_q.push_back(pack_pixel(0, 1, 0));
    pixel_q.push_back(pack_pixel(0, 0, 1));
    pixel_q.push_back(pack_pixel(200, 200, 10));
    pixel_q.push_back(pack_pixel(10, 200, 200));
    pixel_q.push_back(pack_pixel(200, 10, 200));
    pixel_q.push_back(pack_pixel(254, 255, 0));
    pixel_q.push_back(pack_pixel(0, 254, 255));
    pixel_q.push_back(pack_pixel(255, 254, 253));
    pixel_q.push_back(pack_pixel(170, 85, 0));

    // no idling
    queue_random_pixels(PHASE_PIXELS);
    wait_drained();

    // sender idle; the drain above is the full pause of the sender
    send_idle_pct = 45;
    queue_random_pixels(PHASE_PIXELS);
    wait_drained();

    send_idle_pct = 0;
    sink_stall_pct = 45;
    queue_random_pixels(PHASE_PIXELS);
    wait_drained();

    send_idle_pct = 21;
    sink_stall_pct = 21;
    queue_random_pixels(PHASE_PIXELS);
    wait_drained();

    sink_stall_pct = 0;
    repeat (20) @(posedge clk_i);
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
sv/rhc_pkg.sv
sv/rhc_minmax.sv
sv/rhc_scale.sv
sv/rhc_div_step.sv
sv/rhc_finish.sv
sv/rgb_to_hsv_convert_top.sv
tb/sv/testbench.sv
